>>> design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// field widths
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int RROW_W = 5;
	localparam int RCOL_W = 7;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;

	// stream widths, padded to whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	// item kinds carried on tuser
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// character codes and cell constants
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h0F;

	// read request from the sequencer to the cell store
	typedef struct packed {
		logic en;        // read issued this cycle
		logic in_range;  // coordinates lie on the screen
		logic stored;    // cell lies before the cursor, so the memory holds it
	} rd_req_t;

endpackage

>>> design/tcw_cell_store.sv
`timescale 1ns / 1ps

module tcw_cell_store #(
	parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [tcw_pkg::CELL_W-1:0] wr_data,
	input  tcw_pkg::rd_req_t          rd_req,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [tcw_pkg::CELL_W-1:0] rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
	logic [tcw_pkg::CELL_W-1:0] mem_q;
	tcw_pkg::rd_req_t           req_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered; kind of read kept beside the data
	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			req_q <= rd_req;
			if (rd_req.in_range && rd_req.stored) begin
				mem_q <= mem[rd_addr];
			end
		end
	end

	// cells at or past the cursor are blank; off-screen reads give zero
	always_comb begin
		if (!req_q.in_range) begin
			rd_data = '0;
		end else if (req_q.stored) begin
			rd_data = mem_q;
		end else begin
			rd_data = tcw_pkg::BLANK_CELL;
		end
	end

endmodule

>>> design/text_console_writer_core.sv
`timescale 1ns / 1ps

// Channel    Direction  Signals                          Contents (low bit up)
// s_*        in         s_tvalid s_tready s_tdata s_tuser op | char_code read_row read_col
// m_*        out        m_tvalid m_tready m_tdata        cursor_pos cell_value
// attribute  in         cell_attribute_we cell_attribute cell_attribute
//
// Put and clear pass through EXEC and DONE, a read also through RD_ADDR and RD_WAIT; a newline
// sweeps the rest of the row, one memory write per cycle.
// Scrolling moves a row base pointer; only cells before the cursor are held in the
// memory, so reset and clear need no clearing pass.
// One item is worked at a time; a new one is taken while the last result waits.

module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata,  // char_code, read_row, read_col
	input  logic [tcw_pkg::OP_W-1:0]        s_tuser,  // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata,  // cursor_pos, cell_value
	input  logic                            cell_attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]      cell_attribute
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam int PAD_W  = tcw_pkg::OUT_TDATA_W - tcw_pkg::CELL_W - tcw_pkg::POS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RD_ADDR,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic [tcw_pkg::OP_W-1:0]     op_q;
	logic [tcw_pkg::CHAR_W-1:0]   code_q;
	logic [tcw_pkg::RROW_W-1:0]   rrow_q;
	logic [tcw_pkg::RCOL_W-1:0]   rcol_q;
	logic [tcw_pkg::ATTR_W-1:0]   attr_q;
	logic [ROW_W-1:0]             crow_q;
	logic [COL_W-1:0]             ccol_q;
	logic [ADDR_W-1:0]            cbase_q;   // memory address of the cursor row
	logic [ADDR_W-1:0]            tbase_q;   // memory address of the top row
	logic [ADDR_W-1:0]            off_q;
	logic                         range_q;
	logic                         stored_q;
	logic [tcw_pkg::CELL_W-1:0]   cell_q;

	logic [ADDR_W-1:0]            cur_addr;
	logic [ADDR_W:0]              rd_sum;
	logic [ADDR_W-1:0]            rd_addr;
	logic [ADDR_W-1:0]            pos_lin;
	logic                         wr_en;
	logic [ADDR_W-1:0]            wr_addr;
	logic [tcw_pkg::CELL_W-1:0]   wr_data;
	logic [tcw_pkg::CELL_W-1:0]   rd_data;
	tcw_pkg::rd_req_t             rd_req;

	// next row base, wrapping round the memory
	function automatic logic [ADDR_W-1:0] next_base(input logic [ADDR_W-1:0] base);
		logic [ADDR_W:0] nb;
		nb = {1'b0, base} + (ADDR_W + 1)'(COLUMNS);
		if (nb >= (ADDR_W + 1)'(CELLS)) begin
			return '0;
		end
		return nb[ADDR_W-1:0];
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign cur_addr = cbase_q + ADDR_W'(ccol_q);
	assign pos_lin  = ADDR_W'(crow_q) * ADDR_W'(COLUMNS) + ADDR_W'(ccol_q);

	// read address: screen offset plus top row, wrapped
	assign rd_sum  = {1'b0, off_q} + {1'b0, tbase_q};
	assign rd_addr = (rd_sum >= (ADDR_W + 1)'(CELLS)) ?
		ADDR_W'(rd_sum - (ADDR_W + 1)'(CELLS)) : rd_sum[ADDR_W-1:0];

	always_comb begin
		rd_req.en       = (state_q == ST_RD_ADDR);
		rd_req.in_range = range_q;
		rd_req.stored   = stored_q;
	end

	// memory write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_addr;
		wr_data = tcw_pkg::BLANK_CELL;
		case (state_q)
			ST_EXEC: begin
				if (op_q == tcw_pkg::OP_PUT && code_q != tcw_pkg::CODE_NEWLINE) begin
					if (code_q == tcw_pkg::CODE_BACKSPACE) begin
						wr_en   = (ccol_q != '0);
						wr_addr = cur_addr - 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_data = {attr_q, code_q};
					end
				end
			end
			ST_SWEEP: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer, cursor and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			attr_q   <= tcw_pkg::ATTR_RESET;
			crow_q   <= '0;
			ccol_q   <= '0;
			cbase_q  <= '0;
			tbase_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cell_attribute_we) begin
				attr_q <= cell_attribute;
			end
			// a result leaving while the next one is handed over stays valid
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						code_q  <= s_tdata[7:0];
						rrow_q  <= s_tdata[12:8];
						rcol_q  <= s_tdata[19:13];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cell_q  <= '0;
					state_q <= ST_DONE;
					case (op_q)
						tcw_pkg::OP_PUT: begin
							if (code_q == tcw_pkg::CODE_NEWLINE) begin
								state_q <= ST_SWEEP;
							end else if (code_q == tcw_pkg::CODE_BACKSPACE) begin
								if (ccol_q != '0) begin
									ccol_q <= ccol_q - 1'b1;
								end
							end else if (ccol_q == COL_LAST) begin
								ccol_q  <= '0;
								cbase_q <= next_base(cbase_q);
								if (crow_q == ROW_LAST) begin
									tbase_q <= next_base(tbase_q);
								end else begin
									crow_q <= crow_q + 1'b1;
								end
							end else begin
								ccol_q <= ccol_q + 1'b1;
							end
						end
						tcw_pkg::OP_CLEAR: begin
							crow_q  <= '0;
							ccol_q  <= '0;
							cbase_q <= tbase_q;
						end
						tcw_pkg::OP_READ: begin
							off_q    <= ADDR_W'(rrow_q) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_q);
							range_q  <= (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);
							stored_q <= (int'(rrow_q) < int'(crow_q)) ||
								((int'(rrow_q) == int'(crow_q)) && (int'(rcol_q) < int'(ccol_q)));
							state_q  <= ST_RD_ADDR;
						end
						default: begin
						end
					endcase
				end
				// blank the rest of the row, then move to the next one
				ST_SWEEP: begin
					if (ccol_q == COL_LAST) begin
						ccol_q  <= '0;
						cbase_q <= next_base(cbase_q);
						if (crow_q == ROW_LAST) begin
							tbase_q <= next_base(tbase_q);
						end else begin
							crow_q <= crow_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						ccol_q <= ccol_q + 1'b1;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					cell_q  <= rd_data;
					state_q <= ST_DONE;
				end
				// hand over the result once the output register is free
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {{PAD_W{1'b0}}, cell_q, tcw_pkg::POS_W'(pos_lin)};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	tcw_cell_store #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_req  (rd_req),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

>>> tb/tb_text_console_writer_core.sv
`timescale 1ns / 1ps

module tb_text_console_writer_core;

	localparam int COLS  = tcw_pkg::COLUMNS_DEF;
	localparam int ROWS  = tcw_pkg::ROWS_DEF;
	localparam int CELLS = COLS * ROWS;

	// op code with no meaning; the block must leave everything alone
	localparam logic [tcw_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [tcw_pkg::POS_W-1:0]  pos;
		logic [tcw_pkg::CELL_W-1:0] cell_val;
	} console_result_t;

	// screen, cursor and attribute tracker with the results still owed
	class screen_tracker;
		logic [tcw_pkg::CELL_W-1:0] cells [CELLS];
		int unsigned                row;
		int unsigned                col;
		logic [tcw_pkg::ATTR_W-1:0] attribute;
		console_result_t            awaited_results [$];
		int                         errors;

		function new();
			blank_screen();
			attribute = tcw_pkg::ATTR_RESET;
			errors    = 0;
		endfunction

		function void blank_screen();
			foreach (cells[i])
				cells[i] = tcw_pkg::BLANK_CELL;
			row = 0;
			col = 0;
		endfunction

		// next row; past the bottom everything moves up one row
		function void next_row();
			row++;
			if (row >= ROWS) begin
				for (int i = 0; i < (ROWS - 1) * COLS; i++)
					cells[i] = cells[i + COLS];
				for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
					cells[i] = tcw_pkg::BLANK_CELL;
				row = ROWS - 1;
			end
		endfunction

		function void accept_item(logic [tcw_pkg::OP_W-1:0] op,
				logic [tcw_pkg::CHAR_W-1:0] code,
				logic [tcw_pkg::RROW_W-1:0] rrow, logic [tcw_pkg::RCOL_W-1:0] rcol);
			console_result_t res;
			res.cell_val = '0;
			case (op)
				tcw_pkg::OP_PUT: begin
					if (code == tcw_pkg::CODE_NEWLINE) begin
						col = 0;
						next_row();
					end else if (code == tcw_pkg::CODE_BACKSPACE) begin
						if (col > 0) begin
							col--;
							cells[row * COLS + col] = tcw_pkg::BLANK_CELL;
						end
					end else begin
						cells[row * COLS + col] = {attribute, code};
						col++;
						if (col >= COLS) begin
							col = 0;
							next_row();
						end
					end
				end
				tcw_pkg::OP_CLEAR: blank_screen();
				tcw_pkg::OP_READ: begin
					if (rrow < ROWS && rcol < COLS)
						res.cell_val = cells[rrow * COLS + rcol];
				end
				default: ;
			endcase
			res.pos = tcw_pkg::POS_W'(row * COLS + col);
			awaited_results.push_back(res);
		endfunction

		function void check_result(logic [tcw_pkg::OUT_TDATA_W-1:0] data);
			console_result_t want;
			if (awaited_results.size() == 0) begin
				$error("result transfer with nothing awaited: tdata %h", data);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			if (data[tcw_pkg::POS_W-1:0] !== want.pos) begin
				$error("cursor_pos: expected %0d, got %0d", want.pos,
					data[tcw_pkg::POS_W-1:0]);
				errors++;
			end
			if (data[tcw_pkg::POS_W +: tcw_pkg::CELL_W] !== want.cell_val) begin
				$error("cell_value: expected %h, got %h", want.cell_val,
					data[tcw_pkg::POS_W +: tcw_pkg::CELL_W]);
				errors++;
			end
		endfunction
	endclass

	logic                            clk               = 1'b0;
	logic                            arst_n            = 1'b0;
	logic                            s_tvalid          = 1'b0;
	logic                            s_tready;
	logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata           = '0;
	logic [tcw_pkg::OP_W-1:0]        s_tuser           = '0;
	logic                            m_tvalid;
	logic                            m_tready          = 1'b0;
	logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cell_attribute_we = 1'b0;
	logic [tcw_pkg::ATTR_W-1:0]      cell_attribute    = '0;

	screen_tracker screen = new();
	bit            idling = 1'b1;

	text_console_writer_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.cell_attribute_we (cell_attribute_we),
		.cell_attribute    (cell_attribute)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// result side: ready held or dropped in random bursts
	initial begin
		wait (arst_n);
		forever begin
			if (idling && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// result transfers
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			screen.check_result(m_tdata);
	end

	// one input transfer; called just after a rising edge, returns just after the
	// edge that took it, with valid still high
	task automatic send_item(logic [tcw_pkg::OP_W-1:0] op, logic [tcw_pkg::CHAR_W-1:0] code,
			logic [tcw_pkg::RROW_W-1:0] rrow, logic [tcw_pkg::RCOL_W-1:0] rcol);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, rcol, rrow, code};
		do
			@(posedge clk);
		while (!s_tready);
		screen.accept_item(op, code, rrow, rcol);
	endtask

	// drain, then write the attribute register while the block is idle
	task automatic set_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
		s_tvalid <= 1'b0;
		while (screen.awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cell_attribute_we <= 1'b1;
		cell_attribute    <= value;
		@(posedge clk);
		cell_attribute_we <= 1'b0;
		screen.attribute = value;
	endtask

	// random item; newline and backspace shares set the shape of the text
	task automatic random_item(int newline_pct, int backspace_pct);
		logic [tcw_pkg::OP_W-1:0]   op;
		logic [tcw_pkg::CHAR_W-1:0] code;
		logic [tcw_pkg::RROW_W-1:0] rrow;
		logic [tcw_pkg::RCOL_W-1:0] rcol;
		int                         pick;
		code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
		rrow = tcw_pkg::RROW_W'($urandom_range(0, 31));
		rcol = tcw_pkg::RCOL_W'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 399) == 0)
			op = tcw_pkg::OP_CLEAR;
		else if (pick < 2)
			op = OP_SPARE;
		else if (pick < 27)
			op = tcw_pkg::OP_READ;
		else
			op = tcw_pkg::OP_PUT;
		if (op == tcw_pkg::OP_PUT) begin
			pick = $urandom_range(0, 99);
			if (pick < newline_pct)
				code = tcw_pkg::CODE_NEWLINE;
			else if (pick < newline_pct + backspace_pct)
				code = tcw_pkg::CODE_BACKSPACE;
		end else if (op == tcw_pkg::OP_READ) begin
			// mostly on screen, often on the row being written
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				rrow = tcw_pkg::RROW_W'(screen.row);
				rcol = tcw_pkg::RCOL_W'($urandom_range(0, COLS - 1));
			end else if (pick < 9) begin
				rrow = tcw_pkg::RROW_W'($urandom_range(0, ROWS - 1));
				rcol = tcw_pkg::RCOL_W'($urandom_range(0, COLS - 1));
			end
		end
		send_item(op, code, rrow, rcol);
	endtask

	initial begin
		logic [tcw_pkg::ATTR_W-1:0] phase_attr [6];
		int                         newline_share [6];
		phase_attr    = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00, 8'h00};
		newline_share = '{12, 1, 15, 3, 20, 10};
		phase_attr[4] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
		phase_attr[5] = tcw_pkg::ATTR_W'($urandom_range(0, 255));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, edge codes, backspace limits, bad reads, clear
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_PUT, 8'h41, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_PUT, 8'h00, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_PUT, 8'hFF, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd1);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
		send_item(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd2);
		send_item(tcw_pkg::OP_PUT, tcw_pkg::CODE_NEWLINE, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_PUT, tcw_pkg::CODE_BACKSPACE, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_PUT, 8'h80, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd0);
		send_item(tcw_pkg::OP_READ, 8'hFF, tcw_pkg::RROW_W'(ROWS - 1),
			tcw_pkg::RCOL_W'(COLS - 1));
		send_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::RROW_W'(ROWS), 7'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, tcw_pkg::RCOL_W'(COLS));
		send_item(tcw_pkg::OP_READ, 8'h00, 5'h1F, 7'h7F);
		send_item(OP_SPARE, 8'hFF, 5'h1F, 7'h7F);
		send_item(tcw_pkg::OP_PUT, 8'h5A, 5'h1F, 7'h7F);
		send_item(tcw_pkg::OP_CLEAR, 8'hFF, 5'h1F, 7'h7F);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
		send_item(tcw_pkg::OP_READ, 8'h00, 5'd1, 7'd0);

		// random phases, each with its own attribute and line shape
		for (int ph = 0; ph < 6; ph++) begin
			set_attribute(phase_attr[ph]);
			idling = (ph < 5);
			repeat (200) random_item(newline_share[ph], 8);
		end

		s_tvalid <= 1'b0;
		while (screen.awaited_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (screen.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
